// ===== sv/lahm_pkg.sv =====
// ----------------------------------------------------------------------------
// lahm_pkg
// Shared types, constants and register indexes of the anchored header line
// matcher.
// ----------------------------------------------------------------------------
package lahm_pkg;

   // pattern store: six 64-bit registers, lowest byte first
   localparam int PAT_WORDS      = 6;
   localparam int PAT_BYTES      = PAT_WORDS * 8;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_IDX_W      = 3;
   localparam int LEN_W          = 6;
   localparam int CNT_W          = $clog2(PAT_BYTES + 1);
   localparam int MAX_PATTERN    = 48;
   localparam int OFFSET_BITS_DEF = 16;
   localparam int MATCH_OFFSET_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LAST   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 3'd6;

   // scan phase of the current line
   typedef enum logic [1:0] {
      PH_COMPARE,
      PH_TAIL,
      PH_SKIP,
      PH_DONE
   } phase_type;

   // input item
   typedef struct packed {
      logic [7:0] text_byte;
      logic       buffer_end;
   } req_type;

   // result item
   typedef struct packed {
      logic                      found;
      logic [MATCH_OFFSET_W-1:0] match_offset;
   } rsp_type;

   // result handed from the scan stage to the result register
   typedef struct packed {
      logic    emit;
      rsp_type data;
   } result_type;

endpackage

// ===== sv/lahm_chan_if.sv =====
// ----------------------------------------------------------------------------
// lahm_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface lahm_chan_if #(
   parameter type payload_type = lahm_pkg::req_type
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

// ===== sv/lahm_csr.sv =====
// ----------------------------------------------------------------------------
// lahm_csr
// Pattern and length registers, plus a register holding the pattern byte
// at the next match count so the compare path sees a single byte.
// ----------------------------------------------------------------------------
module lahm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [lahm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lahm_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic [lahm_pkg::CNT_W-1:0]          rd_addr,
   output logic [7:0]                          pat_byte,
   output logic [lahm_pkg::LEN_W-1:0]          eff_len
);

   logic [lahm_pkg::PAT_BYTES-1:0][7:0] pattern_ff, pattern_in;
   logic [lahm_pkg::LEN_W-1:0]          length_ff, length_in;
   logic [7:0]                          pat_byte_ff, pat_byte_in;

   // register writes
   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      if (csr_write_en) begin
         for (int w = 0; w < lahm_pkg::PAT_WORDS; w++) begin
            if (csr_index == lahm_pkg::CSR_IDX_W'(w)) begin
               pattern_in[w*8 +: 8] = csr_write_data;
            end
         end
         if (csr_index == lahm_pkg::CSR_PATTERN_LENGTH) begin
            length_in = csr_write_data[lahm_pkg::LEN_W-1:0];
         end
      end
   end

   // byte at the next match count, taken from the updated pattern
   always_comb begin
      if (32'(rd_addr) < lahm_pkg::PAT_BYTES) begin
         pat_byte_in = pattern_in[rd_addr];
      end else begin
         pat_byte_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= '0;
         length_ff   <= lahm_pkg::LEN_W'(1);
         pat_byte_ff <= '0;
      end else begin
         pattern_ff  <= pattern_in;
         length_ff   <= length_in;
         pat_byte_ff <= pat_byte_in;
      end
   end

   // zero acts as one, long lengths clamp to the pattern limit
   always_comb begin
      if (length_ff == '0) begin
         eff_len = lahm_pkg::LEN_W'(1);
      end else if ({1'b0, length_ff} > (lahm_pkg::LEN_W + 1)'(lahm_pkg::MAX_PATTERN)) begin
         eff_len = lahm_pkg::LEN_W'(lahm_pkg::MAX_PATTERN);
      end else begin
         eff_len = length_ff;
      end
   end

   assign pat_byte = pat_byte_ff;

endmodule

// ===== sv/lahm_scan.sv =====
// ----------------------------------------------------------------------------
// lahm_scan
// Input register and per-byte line scanner: compare, tail check and skip
// phases, offsets and the decision of the one result per buffer.
// ----------------------------------------------------------------------------
module lahm_scan #(
   parameter int OFFSET_BITS = lahm_pkg::OFFSET_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   lahm_chan_if.sink                     req_chan,
   input  logic [lahm_pkg::LEN_W-1:0]    eff_len,
   input  logic [7:0]                    pat_byte,
   input  logic                          out_space,
   output lahm_pkg::result_type          res,
   output logic [lahm_pkg::CNT_W-1:0]    mc_next
);

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   function automatic logic is_blank(input logic [7:0] b);
      return (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C);
   endfunction

   logic                         in_valid_ff, in_valid_in;
   lahm_pkg::req_type            item_ff;
   lahm_pkg::phase_type          phase_ff, phase_in, phase_work;
   logic [lahm_pkg::CNT_W-1:0]   mc_ff, mc_in;
   logic [OFFSET_BITS-1:0]       pos_ff, pos_in, lso_ff, lso_in, next_pos;
   logic                         fire, emit, found;

   // input register
   assign fire          = in_valid_ff && out_space;
   assign req_chan.ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff <= req_chan.payload;
      end
   end

   // saturating byte position
   assign next_pos = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;

   // next state and result of the byte in the input register
   always_comb begin
      phase_in   = phase_ff;
      mc_in      = mc_ff;
      pos_in     = pos_ff;
      lso_in     = lso_ff;
      phase_work = phase_ff;
      emit       = 1'b0;
      found      = 1'b0;
      res        = '0;
      if (fire) begin
         // pattern shortened under an ongoing compare
         if (phase_work == lahm_pkg::PH_COMPARE && mc_ff >= eff_len) begin
            phase_work = lahm_pkg::PH_TAIL;
         end
         unique case (phase_work)
            lahm_pkg::PH_COMPARE: begin
               if (item_ff.text_byte == CH_NUL) begin
                  emit = 1'b1;
               end else if (item_ff.text_byte == pat_byte) begin
                  mc_in = mc_ff + 1'b1;
                  if (mc_in >= eff_len) begin
                     phase_work = lahm_pkg::PH_TAIL;
                  end
               end else if (item_ff.text_byte == CH_LF) begin
                  mc_in  = '0;
                  lso_in = next_pos;
               end else begin
                  mc_in      = '0;
                  phase_work = lahm_pkg::PH_SKIP;
               end
            end
            lahm_pkg::PH_TAIL: begin
               if (item_ff.text_byte == CH_NUL || item_ff.text_byte == CH_LF ||
                   item_ff.text_byte == CH_CR) begin
                  emit  = 1'b1;
                  found = 1'b1;
               end else if (!is_blank(item_ff.text_byte)) begin
                  mc_in      = '0;
                  phase_work = lahm_pkg::PH_SKIP;
               end
            end
            lahm_pkg::PH_SKIP: begin
               if (item_ff.text_byte == CH_NUL) begin
                  emit = 1'b1;
               end else if (item_ff.text_byte == CH_LF) begin
                  mc_in      = '0;
                  lso_in     = next_pos;
                  phase_work = lahm_pkg::PH_COMPARE;
               end
            end
            lahm_pkg::PH_DONE: begin
            end
            default: begin
            end
         endcase
         pos_in = next_pos;

         // end of buffer decides whatever is still open
         if (item_ff.buffer_end && !emit && phase_work != lahm_pkg::PH_DONE) begin
            emit  = 1'b1;
            found = (phase_work == lahm_pkg::PH_TAIL);
         end
         if (emit) begin
            phase_work = lahm_pkg::PH_DONE;
         end
         phase_in = phase_work;

         res.emit       = emit;
         res.data.found = found;
         res.data.match_offset = found ? lahm_pkg::MATCH_OFFSET_W'(lso_in) : '0;

         // every buffer starts from a clean scan
         if (item_ff.buffer_end) begin
            phase_in = lahm_pkg::PH_COMPARE;
            mc_in    = '0;
            pos_in   = '0;
            lso_in   = '0;
         end
      end
   end

   assign mc_next = mc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= lahm_pkg::PH_COMPARE;
         mc_ff       <= '0;
         pos_ff      <= '0;
         lso_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         mc_ff       <= mc_in;
         pos_ff      <= pos_in;
         lso_ff      <= lso_in;
      end
   end

endmodule

// ===== sv/lahm_out.sv =====
// ----------------------------------------------------------------------------
// lahm_out
// Result register: holds a finished result until the sink takes it.
// ----------------------------------------------------------------------------
module lahm_out (
   input  logic                 clock,
   input  logic                 reset,
   input  lahm_pkg::result_type res,
   output logic                 out_space,
   lahm_chan_if.source          rsp_chan
);

   logic              valid_ff, valid_in;
   lahm_pkg::rsp_type data_ff;

   // room for a new result when empty or being drained
   assign out_space = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (res.emit) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.emit) begin
         data_ff <= res.data;
      end
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.payload = data_ff;

endmodule

// ===== sv/line_anchored_header_matcher.sv =====
// ----------------------------------------------------------------------------
// line_anchored_header_matcher
// Finds the first line of a byte stream that starts with a configured header
// pattern and ends in whitespace only; one result per buffer.
// ----------------------------------------------------------------------------
//  channel    direction  payload
//  req_chan   in         text_byte[7:0], buffer_end
//  rsp_chan   out        found, match_offset[15:0]
//  csr_*      in         write enable, index[2:0], write data[63:0]
//
// one item per cycle while the result register has room; a deciding item passes
// the input register, then its result is registered in the result register
// the rate is set by the single scan stage that updates phase and match count
// reset is synchronous and active high; it clears scan state and registers
// a held result stalls the scan stage, which in turn stops taking items
// ----------------------------------------------------------------------------
module line_anchored_header_matcher #(
   parameter int OFFSET_BITS = lahm_pkg::OFFSET_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   lahm_chan_if.sink                        req_chan,
   lahm_chan_if.source                      rsp_chan,
   input  logic                             csr_write_en,
   input  logic [lahm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lahm_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   logic [7:0]                  pat_byte;
   logic [lahm_pkg::LEN_W-1:0]  eff_len;
   logic [lahm_pkg::CNT_W-1:0]  mc_next;
   logic                        out_space;
   lahm_pkg::result_type        res;

   // pattern registers
   lahm_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .rd_addr        (mc_next),
      .pat_byte       (pat_byte),
      .eff_len        (eff_len)
   );

   // line scanner
   lahm_scan #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .eff_len   (eff_len),
      .pat_byte  (pat_byte),
      .out_space (out_space),
      .res       (res),
      .mc_next   (mc_next)
   );

   // result register
   lahm_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res       (res),
      .out_space (out_space),
      .rsp_chan  (rsp_chan)
   );

   // a result is only produced when the result register has room
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      res.emit |-> out_space)
      else $error("result produced without room in the result register");

   // a not-found result carries a zero offset
   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      (res.emit && !res.data.found) |-> (res.data.match_offset == '0))
      else $error("not-found result with nonzero offset");

   // a produced result shows up on the output in the next cycle
   a_emit_out: assert property (@(posedge clock) disable iff (reset)
      res.emit |=> rsp_chan.valid)
      else $error("result lost on its way to the output");

endmodule

// ===== tb/line_anchored_header_matcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_anchored_header_matcher_tb
// Self-checking bench for the anchored header line matcher. A short table of
// directed bytes and register writes comes first, then single byte buffers
// under a long result back-pressure, then random buffers built mostly from
// header lines, broken headers and junk lines under several idle and stall
// mixes. A local scan model predicts every result the table does not give.
// ----------------------------------------------------------------------------
module line_anchored_header_matcher_tb;

   localparam int OFFSET_MAX      = (1 << lahm_pkg::OFFSET_BITS_DEF) - 1;
   localparam int DRAIN_CYCLES    = 4;
   localparam int ITEMS_PER_SET   = 125;

   localparam logic [lahm_pkg::CSR_IDX_W-1:0] CSR_PATTERN_FIRST = 3'd0;
   localparam logic [lahm_pkg::CSR_IDX_W-1:0] CSR_UNUSED        = 3'd7;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_VT  = 8'h0B;
   localparam logic [7:0] CH_FF  = 8'h0C;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;

   typedef struct {
      bit                              is_csr;
      logic [lahm_pkg::CSR_IDX_W-1:0]  idx;
      logic [lahm_pkg::CSR_DATA_W-1:0] data;
      logic [7:0]                      text;
      logic                            last;
      bit                              typed;
      lahm_pkg::rsp_type               want;
   } script_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_write_en;
   logic [lahm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [lahm_pkg::CSR_DATA_W-1:0] csr_write_data;

   lahm_chan_if #(.payload_type(lahm_pkg::req_type)) req_if ();
   lahm_chan_if #(.payload_type(lahm_pkg::rsp_type)) rsp_if ();

   line_anchored_header_matcher u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #10 clock = ~clock;

   // local copy of the pattern registers and the scan state
   logic [7:0]                  pat_mem [64];
   logic [lahm_pkg::LEN_W-1:0]  pat_len_raw;
   lahm_pkg::phase_type         scan_ph;
   int unsigned                 cmp_count;
   int unsigned                 pos_count;
   int unsigned                 line_start;

   lahm_pkg::rsp_type           header_results_q [$];
   script_row_type              script_q [$];
   logic [7:0]                  text_q [$];

   int                fail_count;
   int                items_sent;
   int                send_idle_pct;
   int                rsp_stall_pct;
   int                hold_len;
   int                hold_seq;

   function automatic int unsigned eff_pattern_len();
      int unsigned n;
      n = pat_len_raw;
      if (n == 0) n = 1;
      if (n > lahm_pkg::MAX_PATTERN) n = lahm_pkg::MAX_PATTERN;
      return n;
   endfunction

   function automatic void clear_scan_state();
      scan_ph    = lahm_pkg::PH_COMPARE;
      cmp_count  = 0;
      pos_count  = 0;
      line_start = 0;
   endfunction

   // one byte of the scan: phase update, result decision, buffer end clear
   function automatic void scan_text_byte(input logic [7:0] b, input logic last,
                                          output bit emit,
                                          output lahm_pkg::rsp_type res);
      int unsigned next_pos;
      int unsigned len;
      bit          hit;
      next_pos = (pos_count >= OFFSET_MAX) ? OFFSET_MAX : pos_count + 1;
      len      = eff_pattern_len();
      emit     = 1'b0;
      hit      = 1'b0;
      // pattern shortened below the matched count
      if (scan_ph == lahm_pkg::PH_COMPARE && cmp_count >= len) scan_ph = lahm_pkg::PH_TAIL;
      case (scan_ph)
         lahm_pkg::PH_COMPARE: begin
            if (b == CH_NUL) begin
               emit = 1'b1;
            end else if (b == pat_mem[cmp_count % 64]) begin
               cmp_count++;
               if (cmp_count >= len) scan_ph = lahm_pkg::PH_TAIL;
            end else if (b == CH_LF) begin
               cmp_count  = 0;
               line_start = next_pos;
            end else begin
               cmp_count = 0;
               scan_ph   = lahm_pkg::PH_SKIP;
            end
         end
         lahm_pkg::PH_TAIL: begin
            if (b == CH_NUL || b == CH_LF || b == CH_CR) begin
               emit = 1'b1;
               hit  = 1'b1;
            end else if (!(b == CH_SP || b == CH_TAB || b == CH_VT || b == CH_FF)) begin
               cmp_count = 0;
               scan_ph   = lahm_pkg::PH_SKIP;
            end
         end
         lahm_pkg::PH_SKIP: begin
            if (b == CH_NUL) begin
               emit = 1'b1;
            end else if (b == CH_LF) begin
               cmp_count  = 0;
               line_start = next_pos;
               scan_ph    = lahm_pkg::PH_COMPARE;
            end
         end
         default: ;
      endcase
      pos_count = next_pos;
      if (last && !emit && scan_ph != lahm_pkg::PH_DONE) begin
         emit = 1'b1;
         hit  = (scan_ph == lahm_pkg::PH_TAIL);
      end
      res.found        = hit;
      res.match_offset = hit ? 16'(line_start) : '0;
      if (emit) scan_ph = lahm_pkg::PH_DONE;
      if (last) clear_scan_state();
   endfunction

   // directed table rows
   function automatic void add_byte(input logic [7:0] b, input logic last);
      script_row_type r;
      r.is_csr = 1'b0;
      r.idx    = '0;
      r.data   = '0;
      r.text   = b;
      r.last   = last;
      r.typed  = 1'b0;
      r.want   = '0;
      script_q.push_back(r);
   endfunction

   function automatic void add_check(input logic [7:0] b, input logic last,
                                     input logic found, input logic [15:0] offset);
      script_row_type r;
      r.is_csr            = 1'b0;
      r.idx               = '0;
      r.data              = '0;
      r.text              = b;
      r.last              = last;
      r.typed             = 1'b1;
      r.want.found        = found;
      r.want.match_offset = offset;
      script_q.push_back(r);
   endfunction

   function automatic void add_csr(input logic [lahm_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [lahm_pkg::CSR_DATA_W-1:0] data);
      script_row_type r;
      r.is_csr = 1'b1;
      r.idx    = idx;
      r.data   = data;
      r.text   = '0;
      r.last   = 1'b0;
      r.typed  = 1'b0;
      r.want   = '0;
      script_q.push_back(r);
   endfunction

   function automatic logic [7:0] rand_blank();
      case ($urandom_range(3))
         0:       return CH_SP;
         1:       return CH_TAB;
         2:       return CH_VT;
         default: return CH_FF;
      endcase
   endfunction

   // random buffer: header lines, broken headers, junk and raw noise
   function automatic void build_buffer();
      int unsigned len;
      int unsigned n_lines;
      int unsigned kind;
      int unsigned cut;
      text_q.delete();
      len     = eff_pattern_len();
      n_lines = $urandom_range(4, 1);
      for (int l = 0; l < n_lines; l++) begin
         kind = $urandom_range(99);
         if (kind < 50) begin
            for (int k = 0; k < len; k++) text_q.push_back(pat_mem[k]);
            repeat ($urandom_range(3)) text_q.push_back(rand_blank());
            // non-blank byte breaks the tail
            if (kind >= 35) text_q.push_back(8'($urandom_range(8'h7E, 8'h21)));
         end else if (kind < 65) begin
            cut = $urandom_range(len - 1);
            for (int k = 0; k < cut; k++) text_q.push_back(pat_mem[k]);
            text_q.push_back(8'($urandom_range(8'h7E, 8'h21)));
         end else if (kind < 90) begin
            repeat ($urandom_range(10)) text_q.push_back(8'($urandom_range(255, 1)));
         end else begin
            repeat ($urandom_range(6, 1)) text_q.push_back(8'($urandom_range(255)));
         end
         kind = $urandom_range(99);
         if (kind < 50) begin
            text_q.push_back(CH_LF);
         end else if (kind < 75) begin
            text_q.push_back(CH_CR);
            text_q.push_back(CH_LF);
         end else if (kind < 85) begin
            text_q.push_back(CH_NUL);
         end
      end
      if (text_q.size() == 0) text_q.push_back(8'($urandom_range(255)));
   endfunction

   // offer one item, predict it once accepted
   task automatic send_item(input logic [7:0] b, input logic last, input bit typed,
                            input lahm_pkg::rsp_type want);
      bit                emit;
      lahm_pkg::rsp_type got;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid             <= 1'b1;
      req_if.payload.text_byte  <= b;
      req_if.payload.buffer_end <= last;
      do @(posedge clock); while (!req_if.ready);
      scan_text_byte(b, last, emit, got);
      if (typed) header_results_q.push_back(want);
      else if (emit) header_results_q.push_back(got);
   endtask

   task automatic send_text_q();
      foreach (text_q[i]) send_item(text_q[i], i == text_q.size() - 1, 1'b0, '0);
      items_sent += text_q.size();
   endtask

   // sender holds off until every result is out and the pipe is empty
   task automatic wait_block_idle();
      req_if.valid <= 1'b0;
      while (header_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [lahm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [lahm_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      // mirror the write locally
      if (idx <= lahm_pkg::CSR_PATTERN_LAST) begin
         for (int k = 0; k < 8; k++) pat_mem[int'(idx) * 8 + k] = data[8*k +: 8];
      end else if (idx == lahm_pkg::CSR_PATTERN_LENGTH) begin
         pat_len_raw = data[lahm_pkg::LEN_W-1:0];
      end
   endtask

   // new random pattern; sel picks the length, extremes for the low codes
   task automatic program_pattern(input int sel);
      logic [lahm_pkg::CSR_DATA_W-1:0] w;
      int unsigned                     raw;
      wait_block_idle();
      for (int i = 0; i < lahm_pkg::PAT_WORDS; i++) begin
         for (int k = 0; k < 8; k++)
            w[8*k +: 8] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                   : 8'($urandom_range(8'h7E, 8'h21));
         write_csr(lahm_pkg::CSR_IDX_W'(CSR_PATTERN_FIRST + i), w);
      end
      case (sel)
         0:       raw = 1;
         1:       raw = lahm_pkg::MAX_PATTERN;
         2:       raw = 63;              // beyond the max, clamps
         3:       raw = 0;               // acts as one
         default: raw = $urandom_range(6, 1);
      endcase
      w                        = {$urandom, $urandom};
      w[lahm_pkg::LEN_W-1:0]   = lahm_pkg::LEN_W'(raw);
      write_csr(lahm_pkg::CSR_PATTERN_LENGTH, w);
      if ($urandom_range(3) == 0) write_csr(CSR_UNUSED, {$urandom, $urandom});
   endtask

   // result ready: random stalls, or a long hold-off on request
   initial begin
      int hold_cnt;
      int hold_seen;
      hold_cnt     = 0;
      hold_seen    = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_cnt  = hold_len;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      lahm_pkg::rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (header_results_q.size() == 0) begin
            $display("[%0t] unexpected result: expected none, actual found %0d offset %0d",
                     $time, rsp_if.payload.found, rsp_if.payload.match_offset);
            fail_count++;
         end else begin
            want = header_results_q.pop_front();
            if (rsp_if.payload.found !== want.found) begin
               $display("[%0t] found mismatch: expected %0d, actual %0d",
                        $time, want.found, rsp_if.payload.found);
               fail_count++;
            end
            if (rsp_if.payload.match_offset !== want.match_offset) begin
               $display("[%0t] match_offset mismatch: expected %0d, actual %0d",
                        $time, want.match_offset, rsp_if.payload.match_offset);
               fail_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      fail_count     = 0;
      items_sent     = 0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      hold_len       = 0;
      hold_seq       = 0;
      foreach (pat_mem[i]) pat_mem[i] = '0;
      pat_len_raw    = lahm_pkg::LEN_W'(1);
      clear_scan_state();
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_write_en   <= 1'b0;
      csr_index      <= '0;
      csr_write_data <= '0;

      // directed table
      add_check(CH_NUL, 1'b0, 1'b0, 16'd0);      // zero pattern byte never matches
      add_byte("A", 1'b1);                       // ignored after the result
      add_csr(CSR_PATTERN_FIRST, 64'h3A4B);      // "K:"
      add_csr(lahm_pkg::CSR_PATTERN_LENGTH, 64'd2);
      add_byte("K", 1'b0);
      add_byte(":", 1'b0);
      add_byte(CH_SP, 1'b0);
      add_check(CH_CR, 1'b0, 1'b1, 16'd0);
      add_byte(8'hFF, 1'b1);
      add_byte(CH_LF, 1'b0);                     // mismatching lf opens a line
      add_byte("K", 1'b0);
      add_check(":", 1'b1, 1'b1, 16'd1);         // complete at buffer end
      add_byte("K", 1'b0);
      add_csr(lahm_pkg::CSR_PATTERN_LENGTH, 64'd1);        // shortened mid compare
      add_byte(CH_SP, 1'b0);
      add_check(CH_LF, 1'b1, 1'b1, 16'd0);
      add_csr(lahm_pkg::CSR_PATTERN_LENGTH, 64'd0);        // zero length acts as one
      add_byte("K", 1'b0);
      add_check(CH_TAB, 1'b1, 1'b1, 16'd0);
      add_byte(8'hFF, 1'b0);
      add_byte(CH_LF, 1'b0);
      add_byte("b", 1'b0);
      add_check(CH_NUL, 1'b0, 1'b0, 16'd0);
      add_byte("c", 1'b1);
      add_byte("K", 1'b0);                       // blank tail broken by a letter
      add_byte(CH_VT, 1'b0);
      add_byte(CH_FF, 1'b0);
      add_byte("x", 1'b0);
      add_byte(CH_LF, 1'b1);
      add_csr(CSR_PATTERN_FIRST, 64'h4B0A);      // lf inside the pattern
      add_csr(lahm_pkg::CSR_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFC2);
      add_byte(CH_LF, 1'b0);
      add_byte("K", 1'b0);
      add_check(CH_LF, 1'b1, 1'b1, 16'd0);
      add_csr(CSR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (script_q[i]) begin
         if (script_q[i].is_csr) begin
            wait_block_idle();
            write_csr(script_q[i].idx, script_q[i].data);
         end else begin
            send_item(script_q[i].text, script_q[i].last, script_q[i].typed,
                      script_q[i].want);
         end
      end

      // results held back while single byte buffers keep coming
      wait_block_idle();
      hold_len = 400;
      hold_seq++;
      repeat (40) send_item(8'($urandom_range(255)), 1'b1, 1'b0, '0);
      wait_block_idle();

      // random buffers under each idle mix
      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 65; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 65; end
            default: begin send_idle_pct = 38; rsp_stall_pct = 38; end
         endcase
         for (int s = 0; s < 4; s++) begin
            program_pattern(s + 4 * (mode % 2));
            items_sent = 0;
            while (items_sent < ITEMS_PER_SET) begin
               build_buffer();
               send_text_q();
            end
         end
      end

      wait_block_idle();
      repeat (DRAIN_CYCLES * 4) @(posedge clock);
      if (header_results_q.size() != 0) begin
         $display("[%0t] %0d expected results never arrived", $time,
                  header_results_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
